// File: src/sha_pkg.sv
package sha_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned ROUNDS = 64;
	localparam int unsigned HASH_WORDS = 8;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam logic [7:0] PAD_MARK = 8'h80;

	// one queued command: a message byte and/or the end of the message
	typedef struct packed {
		logic       has_byte;
		logic       last;
		logic [7:0] data;
	} cmd_t;

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] HASH_IV [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// File: src/sha_front.sv
module sha_front (
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] data_byte
	input  logic          s_tlast,   // is_last
	input  logic          s_tuser,   // no_data
	input  logic          q_full,
	output logic          q_push,
	output sha_pkg::cmd_t q_cmd
);
	import sha_pkg::*;

	logic xfer;

	assign s_tready = !q_full;
	assign xfer     = s_tvalid && !q_full;

	// a transaction with neither byte nor end mark does nothing, so it is dropped here
	assign q_push        = xfer && (!s_tuser || s_tlast);
	assign q_cmd.has_byte = !s_tuser;
	assign q_cmd.last     = s_tlast;
	assign q_cmd.data     = s_tdata;

endmodule

// File: src/sha_cmdq.sv
module sha_cmdq #(
	parameter int unsigned DEPTH = sha_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sha_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          pop_valid,
	input  logic          pop,
	output sha_pkg::cmd_t pop_cmd
);
	import sha_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (cnt_q == FULL_CNT);
	assign pop_valid = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;
	assign pop_cmd   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/sha_engine.sv
module sha_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  sha_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic          m_tlast,
	output logic [2:0]    m_tuser
);
	import sha_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LEN   = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	// what follows the running compression
	typedef enum logic [1:0] {
		PH_ABSORB = 2'd0,
		PH_MARK   = 2'd1,
		PH_FINAL  = 2'd2
	} phase_t;

	state_t      state_q;
	phase_t      phase_q;
	logic        last_pend_q;
	logic [63:0] cnt_q;
	logic [31:0] blk_q  [BLOCK_WORDS];
	logic [31:0] hash_q [HASH_WORDS];
	logic [31:0] var_q  [8];
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;

	logic [5:0]  pos;
	logic [3:0]  wsel;
	logic [4:0]  bsh;
	logic [31:0] w_next;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;
	logic        out_load;

	assign pos  = cnt_q[8:3];
	assign wsel = pos[5:2];
	assign bsh  = {~pos[1:0], 3'b000};

	assign w_next = ssig1(blk_q[14]) + blk_q[9] + ssig0(blk_q[1]) + blk_q[0];
	assign ch     = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign maj    = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign t1     = var_q[7] + bsig1(var_q[4]) + ch + ROUND_K[rnd_q] + blk_q[0];
	assign t2     = bsig0(var_q[0]) + maj;

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_idx_q;
	assign m_tlast  = out_last_q;

	// round datapath and output register
	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end else begin
			for (int i = 0; i < 8; i++) begin
				var_q[i] <= hash_q[i];
			end
		end
		if (out_load) begin
			out_data_q <= hash_q[oidx_q];
			out_idx_q  <= oidx_q;
			out_last_q <= (oidx_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_ABSORB;
			last_pend_q <= 1'b0;
			cnt_q       <= '0;
			rnd_q       <= '0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < BLOCK_WORDS; i++) begin
				blk_q[i] <= '0;
			end
			for (int i = 0; i < HASH_WORDS; i++) begin
				hash_q[i] <= HASH_IV[i];
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						last_pend_q <= cmd.last;
						phase_q     <= PH_ABSORB;
						rnd_q       <= '0;
						if (cmd.has_byte) begin
							blk_q[wsel][bsh +: 8] <= cmd.data;
							cnt_q <= cnt_q + 64'd8;
						end
						if (cmd.has_byte && pos == 6'd63) begin
							state_q <= ST_ROUND;
						end else if (cmd.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					blk_q[wsel][bsh +: 8] <= PAD_MARK;
					rnd_q   <= '0;
					state_q <= ST_ROUND;
					if (pos[5:3] == 3'd7) begin
						// no room for the length: it goes in an extra block
						phase_q <= PH_MARK;
					end else begin
						blk_q[14] <= cnt_q[63:32];
						blk_q[15] <= cnt_q[31:0];
						phase_q   <= PH_FINAL;
					end
				end
				ST_LEN: begin
					blk_q[14] <= cnt_q[63:32];
					blk_q[15] <= cnt_q[31:0];
					phase_q   <= PH_FINAL;
					rnd_q     <= '0;
					state_q   <= ST_ROUND;
				end
				ST_ROUND: begin
					for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
						blk_q[i] <= blk_q[i + 1];
					end
					blk_q[BLOCK_WORDS - 1] <= w_next;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'(ROUNDS - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < HASH_WORDS; i++) begin
						hash_q[i] <= hash_q[i] + var_q[i];
					end
					for (int i = 0; i < BLOCK_WORDS; i++) begin
						blk_q[i] <= '0;
					end
					oidx_q <= '0;
					unique case (phase_q)
						PH_ABSORB: state_q <= last_pend_q ? ST_PAD : ST_IDLE;
						PH_MARK:   state_q <= ST_LEN;
						PH_FINAL:  state_q <= ST_OUT;
						default:   state_q <= ST_IDLE;
					endcase
				end
				ST_OUT: begin
					if (out_load) begin
						oidx_q <= oidx_q + 1'b1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < HASH_WORDS; i++) begin
								hash_q[i] <= HASH_IV[i];
							end
							cnt_q       <= '0;
							last_pend_q <= 1'b0;
							phase_q     <= PH_ABSORB;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/sha256_byte_stream_hasher_core.sv
// SHA-256 over a byte stream. Bytes arrive one per transaction, tlast on the final one;
// tuser=1 marks a transaction without a byte, which only matters together with tlast
// (it ends the message, an empty one if nothing came before). The digest leaves as eight
// 32-bit transactions, H0 first, word index in tuser, tlast on the eighth. The engine
// takes bytes while idle; each full 64-byte block then goes through the single round
// unit (one round per cycle, then the hash add) before the next byte is taken. Ending a
// message pads and compresses one more block, or two when the 0x80 mark lands in the last
// eight bytes of a block, then sends the digest. A small command queue sits between
// the input and the engine, so input is taken while a block is being compressed until
// the queue fills.
module sha256_byte_stream_hasher_core #(
	parameter int unsigned QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // is_last
	input  logic        s_tuser,   // no_data
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast,   // last_word
	output logic [2:0]  m_tuser    // [2:0] word_index
);
	import sha_pkg::*;

	cmd_t in_cmd;
	cmd_t eng_cmd;
	logic q_push;
	logic q_full;
	logic q_valid;
	logic q_pop;

	sha_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (in_cmd)
	);

	sha_cmdq #(
		.DEPTH (QUEUE_DEPTH)
	) u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (in_cmd),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_cmd   (eng_cmd)
	);

	sha_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (eng_cmd),
		.cmd_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

// File: src/sha_checker.sv
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic [2:0]  m_tuser
);

	logic [2:0] exp_idx_q;

	// index the next digest word should carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (m_tvalid && m_tready) begin
			exp_idx_q <= m_tlast ? 3'd0 : m_tuser + 3'd1;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("digest transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("digest transaction changed while stalled");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
		else $error("tlast does not match the final word index");

	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == exp_idx_q))
		else $error("digest words out of order");

endmodule

bind sha256_byte_stream_hasher_core sha_checker u_sha_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
